FILE: sv/dpq_pkg.sv
package dpq_pkg;

   localparam int DPQ_POOL_DEPTH  = 64;
   localparam int DPQ_QUEUE_DEPTH = 2;
   localparam int DPQ_SQ_W        = 50;
   localparam int DPQ_RSQ_W       = 46;

   typedef enum logic [2:0] {
      REQ_INSERT = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_LOOKUP = 3'd2,
      REQ_QUERY  = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_NOT_FOUND = 2'd1,
      STS_FULL      = 2'd2,
      STS_DUP       = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [15:0]        entry_id;
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic signed [23:0] pos_z;
      logic [22:0]        query_range;
      logic [31:0]        entry_payload;
   } dpq_req_type;

   typedef struct packed {
      status_type         status;
      logic [15:0]        hit_id;
      logic signed [23:0] hit_x;
      logic signed [23:0] hit_y;
      logic signed [23:0] hit_z;
      logic [31:0]        hit_payload;
      logic               last_result;
   } dpq_rsp_type;

   typedef struct packed {
      logic [15:0]        id;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic signed [23:0] z;
      logic [31:0]        payload;
   } dpq_entry_type;

   typedef struct packed {
      req_code_type code;
      dpq_req_type  req;
   } dpq_cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_RD,
      BK_CHK,
      BK_SQ,
      BK_CMP,
      BK_MOVE_RD,
      BK_MOVE_WR,
      BK_EMIT,
      BK_FINAL
   } bk_state_type;

endpackage

FILE: sv/dpq_front.sv
module dpq_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dpq_pkg::dpq_req_type req_data,
   output logic                 q_valid,
   input  logic                 q_pop,
   output dpq_pkg::dpq_cmd_type q_cmd
);
   import dpq_pkg::*;

   localparam int QAW = $clog2(DPQ_QUEUE_DEPTH);
   localparam int QCW = $clog2(DPQ_QUEUE_DEPTH + 1);

   dpq_cmd_type    qmem_ff [DPQ_QUEUE_DEPTH];
   logic [QAW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0] fill_ff, fill_in;
   logic           known;
   logic           push;
   dpq_cmd_type    cmd;

   always_comb begin
      cmd.req  = req_data;
      cmd.code = REQ_INSERT;
      known    = 1'b1;
      unique case (req_data.req_type)
         REQ_INSERT: cmd.code = REQ_INSERT;
         REQ_REMOVE: cmd.code = REQ_REMOVE;
         REQ_LOOKUP: cmd.code = REQ_LOOKUP;
         REQ_QUERY:  cmd.code = REQ_QUERY;
         REQ_CLEAR:  cmd.code = REQ_CLEAR;
         default:    known = 1'b0;
      endcase
   end

   assign req_stall = (fill_ff == QCW'(DPQ_QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && known;
   assign q_valid   = (fill_ff != '0);
   assign q_cmd     = qmem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(DPQ_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (q_pop && q_valid) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(DPQ_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (push && !(q_pop && q_valid)) begin
         fill_in = fill_ff + QCW'(1);
      end else if (!push && q_pop && q_valid) begin
         fill_in = fill_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         qmem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

FILE: sv/dpq_back.sv
module dpq_back #(
   parameter int  POOL_DEPTH = dpq_pkg::DPQ_POOL_DEPTH,
   localparam int CW         = $clog2(POOL_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  dpq_pkg::dpq_cmd_type q_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dpq_pkg::dpq_rsp_type rsp_data,
   output logic [CW-1:0]        live_count
);
   import dpq_pkg::*;

   localparam int AW = $clog2(POOL_DEPTH);

   bk_state_type         state_ff, state_in;
   dpq_cmd_type          cur_ff, cur_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        slot_ff, slot_in;
   dpq_rsp_type          res_ff, res_in;
   dpq_entry_type        pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   dpq_entry_type        cand_ff, cand_in;
   logic [DPQ_SQ_W-1:0]  sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic [DPQ_RSQ_W-1:0] rsq_ff, rsq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   dpq_rsp_type          rsp_ff, rsp_in;

   dpq_entry_type        mem [POOL_DEPTH];
   dpq_entry_type        rd_q;
   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_wa, mem_ra;
   dpq_entry_type        mem_wd;

   logic                 can_emit;
   logic [CW-1:0]        last_idx;
   logic [DPQ_SQ_W+1:0]  dsum;
   dpq_entry_type        new_entry;

   function automatic logic [DPQ_SQ_W-1:0] sq_diff(logic signed [23:0] a,
                                                   logic signed [23:0] b);
      logic signed [24:0] d;
      logic [24:0]        m;
      d = {a[23], a} - {b[23], b};
      m = d[24] ? 25'(-d) : 25'(d);
      return DPQ_SQ_W'(m * m);
   endfunction

   function automatic dpq_rsp_type mk_hit(dpq_entry_type e, logic last);
      dpq_rsp_type r;
      r.status      = STS_OK;
      r.hit_id      = e.id;
      r.hit_x       = e.x;
      r.hit_y       = e.y;
      r.hit_z       = e.z;
      r.hit_payload = e.payload;
      r.last_result = last;
      return r;
   endfunction

   function automatic dpq_rsp_type mk_blank(status_type s, logic [15:0] id);
      dpq_rsp_type r;
      r             = '0;
      r.status      = s;
      r.hit_id      = id;
      r.last_result = 1'b1;
      return r;
   endfunction

   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign last_idx   = count_ff - CW'(1);
   assign dsum       = {2'b00, sqx_ff} + {2'b00, sqy_ff} + {2'b00, sqz_ff};
   assign new_entry  = '{id: cur_ff.req.entry_id, x: cur_ff.req.pos_x,
                         y: cur_ff.req.pos_y, z: cur_ff.req.pos_z,
                         payload: cur_ff.req.entry_payload};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign live_count = count_ff;

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      res_in        = res_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cand_in       = cand_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      sqz_in        = sqz_ff;
      rsq_in        = rsq_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd        = new_entry;
      mem_re        = 1'b0;
      mem_ra        = idx_ff[AW-1:0];
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cur_in        = q_cmd;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               rsq_in        = DPQ_RSQ_W'(q_cmd.req.query_range * q_cmd.req.query_range);
               unique case (q_cmd.code)
                  REQ_CLEAR: begin
                     count_in = '0;
                     res_in   = mk_blank(STS_OK, 16'd0);
                     state_in = BK_EMIT;
                  end
                  REQ_INSERT: begin
                     if (count_ff >= CW'(POOL_DEPTH)) begin
                        res_in   = mk_blank(STS_FULL, q_cmd.req.entry_id);
                        state_in = BK_EMIT;
                     end else begin
                        state_in = BK_RD;
                     end
                  end
                  REQ_REMOVE, REQ_LOOKUP, REQ_QUERY: state_in = BK_RD;
                  default: state_in = BK_IDLE;
               endcase
            end
         end
         BK_RD: begin
            if (idx_ff >= count_ff) begin
               unique case (cur_ff.code)
                  REQ_INSERT: begin
                     mem_we   = 1'b1;
                     mem_wa   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     res_in   = mk_hit(new_entry, 1'b1);
                     state_in = BK_EMIT;
                  end
                  REQ_QUERY: state_in = BK_FINAL;
                  default: begin
                     res_in   = mk_blank(STS_NOT_FOUND, cur_ff.req.entry_id);
                     state_in = BK_EMIT;
                  end
               endcase
            end else begin
               mem_re   = 1'b1;
               state_in = (cur_ff.code == REQ_QUERY) ? BK_SQ : BK_CHK;
            end
         end
         BK_CHK: begin
            if (rd_q.id == cur_ff.req.entry_id) begin
               unique case (cur_ff.code)
                  REQ_INSERT: begin
                     res_in   = mk_blank(STS_DUP, cur_ff.req.entry_id);
                     state_in = BK_EMIT;
                  end
                  REQ_REMOVE: begin
                     res_in   = mk_hit(rd_q, 1'b1);
                     slot_in  = idx_ff[AW-1:0];
                     state_in = BK_MOVE_RD;
                  end
                  default: begin
                     res_in   = mk_hit(rd_q, 1'b1);
                     state_in = BK_EMIT;
                  end
               endcase
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = BK_RD;
            end
         end
         BK_MOVE_RD: begin
            mem_re   = 1'b1;
            mem_ra   = last_idx[AW-1:0];
            count_in = last_idx;
            state_in = BK_MOVE_WR;
         end
         BK_MOVE_WR: begin
            mem_we   = 1'b1;
            mem_wa   = slot_ff;
            mem_wd   = rd_q;
            state_in = BK_EMIT;
         end
         BK_SQ: begin
            cand_in  = rd_q;
            sqx_in   = sq_diff(rd_q.x, cur_ff.req.pos_x);
            sqy_in   = sq_diff(rd_q.y, cur_ff.req.pos_y);
            sqz_in   = sq_diff(rd_q.z, cur_ff.req.pos_z);
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (dsum <= {6'd0, rsq_ff}) begin
               if (!pend_valid_ff || can_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = mk_hit(pend_ff, 1'b0);
                  end
                  pend_in       = cand_ff;
                  pend_valid_in = 1'b1;
                  idx_in        = idx_ff + CW'(1);
                  state_in      = BK_RD;
               end
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = BK_RD;
            end
         end
         BK_FINAL: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_valid_ff ? mk_hit(pend_ff, 1'b1)
                                            : mk_blank(STS_NOT_FOUND, 16'd0);
               state_in     = BK_IDLE;
            end
         end
         BK_EMIT: begin
            if (can_emit) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      idx_ff  <= idx_in;
      slot_ff <= slot_in;
      res_ff  <= res_in;
      pend_ff <= pend_in;
      cand_ff <= cand_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sqz_ff  <= sqz_in;
      rsq_ff  <= rsq_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_q <= mem[mem_ra];
      end
   end

endmodule

FILE: sv/dense_pool_radius_query.sv
// Dense pool of up to POOL_DEPTH entries (id, Q19.4 position, payload word)
// with insert, remove by id, position lookup, range query and clear.
// Requests enter on req_valid/req_stall with req_data; a request transfers
// when req_valid is high and req_stall low. Unknown request types transfer
// and are dropped without a result. Results leave on rsp_valid/rsp_stall
// with rsp_data; last_result marks the final result of each request.
// A two-entry request queue sits in front of the execution engine, and one
// output register behind it, so requests keep transferring while a result
// waits. Insert, remove and lookup scan live entries by id, one entry at a
// time through the entry memory's single read port; remove then moves the
// last entry into the gap. A range query reads, squares and compares each
// live entry in turn. Requests are carried out one at a time.
// Reset empties the pool and both channels; the memory itself is not
// cleared. A stall on rsp_stall holds the result and, once another result
// is due, holds the engine at that point.
module dense_pool_radius_query #(
   parameter int POOL_DEPTH = dpq_pkg::DPQ_POOL_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dpq_pkg::dpq_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dpq_pkg::dpq_rsp_type rsp_data
);
   import dpq_pkg::*;

   localparam int CW = $clog2(POOL_DEPTH + 1);

   logic          q_valid;
   logic          q_pop;
   dpq_cmd_type   q_cmd;
   logic [CW-1:0] live_count;

   dpq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_cmd     (q_cmd)
   );

   dpq_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_cmd      (q_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .live_count (live_count)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      live_count <= CW'(POOL_DEPTH))
      else $error("live count above pool depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (live_count != $past(live_count)) |->
         (live_count == $past(live_count) + CW'(1) ||
          live_count == $past(live_count) - CW'(1) || live_count == '0))
      else $error("live count jumped");

   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_result) |-> (rsp_data.status == STS_OK))
      else $error("non-final result without hit status");

   a_dup_blank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STS_DUP) |->
         (rsp_data.last_result && rsp_data.hit_x == '0 && rsp_data.hit_payload == '0))
      else $error("duplicate result carries entry data");

endmodule

FILE: bench/testbench.sv
module testbench;
   import dpq_pkg::*;

   localparam int DEPTH      = DPQ_POOL_DEPTH;
   localparam int IDLE_LIMIT = 20000;
   localparam int N_RANDOM   = 40;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   dpq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   dpq_rsp_type rsp_data;

   dense_pool_radius_query uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   dpq_entry_type pool[DEPTH];
   int            live;
   dpq_rsp_type   pending_rsp[$];
   int            errors;
   int            idle_cycles;
   int            rsp_count;
   int            query_hits;
   bit            quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic dpq_rsp_type mk_rsp(status_type s, logic [15:0] id,
                                          logic [23:0] x, logic [23:0] y,
                                          logic [23:0] z, logic [31:0] p);
      dpq_rsp_type r;
      r.status = s; r.hit_id = id; r.hit_x = x; r.hit_y = y; r.hit_z = z;
      r.hit_payload = p; r.last_result = 1'b1;
      return r;
   endfunction

   function automatic dpq_rsp_type entry_rsp(dpq_entry_type e);
      return mk_rsp(STS_OK, e.id, e.x, e.y, e.z, e.payload);
   endfunction

   function automatic int slot_of(logic [15:0] id);
      for (int i = 0; i < live; i++)
         if (pool[i].id == id) return i;
      return -1;
   endfunction

   function automatic longint sqd(logic signed [23:0] a, logic signed [23:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
   endfunction

   task automatic queue_rsp(dpq_rsp_type r);
      pending_rsp = {pending_rsp, r};
   endtask

   task automatic predict_pool(dpq_req_type q);
      int s;
      int n;
      longint rsq;
      dpq_entry_type e;
      dpq_rsp_type r;
      case (q.req_type)
         REQ_INSERT: begin
            if (live >= DEPTH) queue_rsp(mk_rsp(STS_FULL, q.entry_id, 0, 0, 0, 0));
            else if (slot_of(q.entry_id) >= 0)
               queue_rsp(mk_rsp(STS_DUP, q.entry_id, 0, 0, 0, 0));
            else begin
               e.id = q.entry_id; e.x = q.pos_x; e.y = q.pos_y; e.z = q.pos_z;
               e.payload = q.entry_payload;
               pool[live] = e;
               live++;
               queue_rsp(entry_rsp(e));
            end
         end
         REQ_REMOVE, REQ_LOOKUP: begin
            s = slot_of(q.entry_id);
            if (s < 0) queue_rsp(mk_rsp(STS_NOT_FOUND, q.entry_id, 0, 0, 0, 0));
            else begin
               queue_rsp(entry_rsp(pool[s]));
               if (q.req_type == REQ_REMOVE) begin
                  pool[s] = pool[live - 1];
                  live--;
               end
            end
         end
         REQ_QUERY: begin
            rsq = longint'(q.query_range) * longint'(q.query_range);
            n = 0;
            for (int i = 0; i < live; i++) begin
               if (sqd(pool[i].x, q.pos_x) + sqd(pool[i].y, q.pos_y)
                   + sqd(pool[i].z, q.pos_z) <= rsq) begin
                  r = entry_rsp(pool[i]);
                  r.last_result = 1'b0;
                  queue_rsp(r);
                  n++;
               end
            end
            query_hits += n;
            if (n == 0) queue_rsp(mk_rsp(STS_NOT_FOUND, 0, 0, 0, 0, 0));
            else pending_rsp[$].last_result = 1'b1;
         end
         REQ_CLEAR: begin
            live = 0;
            queue_rsp(mk_rsp(STS_OK, 0, 0, 0, 0, 0));
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   always @(posedge clock) begin
      dpq_rsp_type w;
      if (reset) idle_cycles <= 0;
      else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout, nothing transferred");
            $display("FAILURE");
            $finish;
         end
         if (req_valid && !req_stall) predict_pool(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (pending_rsp.size() == 0)
               report_mismatch("unexpected result", 64'(rsp_data.hit_id), 64'(0));
            else begin
               w = pending_rsp.pop_front();
               if (rsp_data.status !== w.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(w.status));
               if (rsp_data.hit_id !== w.hit_id)
                  report_mismatch("hit_id", 64'(rsp_data.hit_id), 64'(w.hit_id));
               if (rsp_data.hit_x !== w.hit_x)
                  report_mismatch("hit_x", 64'(rsp_data.hit_x), 64'(w.hit_x));
               if (rsp_data.hit_y !== w.hit_y)
                  report_mismatch("hit_y", 64'(rsp_data.hit_y), 64'(w.hit_y));
               if (rsp_data.hit_z !== w.hit_z)
                  report_mismatch("hit_z", 64'(rsp_data.hit_z), 64'(w.hit_z));
               if (rsp_data.hit_payload !== w.hit_payload)
                  report_mismatch("hit_payload", 64'(rsp_data.hit_payload),
                                  64'(w.hit_payload));
               if (rsp_data.last_result !== w.last_result)
                  report_mismatch("last_result", 64'(rsp_data.last_result),
                                  64'(w.last_result));
            end
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic dpq_req_type mk_req(req_code_type t, logic [15:0] id,
                                          logic [23:0] x, logic [23:0] y,
                                          logic [23:0] z, logic [22:0] rg,
                                          logic [31:0] p);
      dpq_req_type q;
      q.req_type = t; q.entry_id = id; q.pos_x = x; q.pos_y = y; q.pos_z = z;
      q.query_range = rg; q.entry_payload = p;
      return q;
   endfunction

   // drive one request; data set at negedge, held until transferred
   task automatic send_req(dpq_req_type q);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   function automatic logic [23:0] rnd_pos(bit near);
      if (near) return 24'($signed($urandom_range(0, 64)) - 32);
      return 24'($urandom);
   endfunction

   dpq_req_type directed[$];
   dpq_req_type q;
   logic [15:0] ids[$];
   int k;
   int full_count;

   task automatic add_row(dpq_req_type r);
      directed = {directed, r};
   endtask

   initial begin
      reset = 1'b1; req_valid = 1'b0; req_data = '0;
      errors = 0; live = 0; rsp_count = 0; query_hits = 0; quiet = 0; full_count = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(mk_req(REQ_LOOKUP, 16'h0000, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_QUERY, 0, 0, 0, 0, 23'h7fffff, 0));
      add_row(mk_req(REQ_INSERT, 16'hffff, 24'h7fffff, 24'h800000, 24'h7fffff,
                     0, 32'hffffffff));
      add_row(mk_req(REQ_INSERT, 16'h0000, 24'h800000, 24'h7fffff, 24'h800000,
                     23'h7fffff, 32'h0));
      add_row(mk_req(REQ_INSERT, 16'hffff, 1, 2, 3, 0, 5));
      add_row(mk_req(REQ_INSERT, 16'h1234, 0, 0, 0, 0, 32'h5a5a5a5a));
      add_row(mk_req(REQ_QUERY, 0, 0, 0, 0, 23'h7fffff, 0));
      add_row(mk_req(REQ_QUERY, 0, 24'h7fffff, 24'h800000, 24'h7fffff, 0, 0));
      add_row(mk_req(REQ_QUERY, 0, 24'h000010, 0, 0, 23'h10, 0));
      add_row(mk_req(REQ_QUERY, 0, 24'h000011, 0, 0, 23'h10, 0));
      add_row(mk_req(req_code_type'(3'd5), 16'h1234, 0, 0, 0, 0, 0));
      add_row(mk_req(req_code_type'(3'd7), 16'hffff, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_LOOKUP, 16'hffff, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_REMOVE, 16'hffff, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_LOOKUP, 16'h1234, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_REMOVE, 16'hffff, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_REMOVE, 16'h1234, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(REQ_LOOKUP, 16'h0000, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_req(directed[i]);

      // fill to capacity, then hit the full case
      for (int i = 0; i < DEPTH + 2; i++) begin
         q = mk_req(REQ_INSERT, 16'(i * 977 + 3), rnd_pos(1), rnd_pos(1), rnd_pos(1), 0,
                    $urandom);
         if (live >= DEPTH) full_count++;
         send_req(q);
      end
      send_req(mk_req(REQ_QUERY, 0, 0, 0, 0, 23'd40, 0));
      send_req(mk_req(REQ_REMOVE, 16'd3, 0, 0, 0, 0, 0));
      send_req(mk_req(REQ_QUERY, 0, 0, 0, 0, 23'h7fffff, 0));
      wait_drain();
      send_req(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0, 0));

      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 30) begin
            wait_drain();
            quiet = 1;
         end
         k = $urandom_range(0, 99);
         if (k < 40 || ids.size() == 0) begin
            q = mk_req(REQ_INSERT, 16'($urandom), rnd_pos(k % 3 != 0), rnd_pos(k % 3 != 0),
                       rnd_pos(k % 3 != 0), 23'($urandom), $urandom);
            if ($urandom_range(0, 5) == 0 && ids.size() != 0)
               q.entry_id = ids[$urandom_range(0, ids.size() - 1)];
            ids = {ids, q.entry_id};
         end else if (k < 55) begin
            q = mk_req(REQ_REMOVE, ids[$urandom_range(0, ids.size() - 1)], 0, 0, 0, 0, 0);
            if (k < 45) q.entry_id = 16'($urandom);
         end else if (k < 70) begin
            q = mk_req(REQ_LOOKUP, ids[$urandom_range(0, ids.size() - 1)], 0, 0, 0, 0, 0);
            if (k < 58) q.entry_id = 16'($urandom);
         end else if (k < 94) begin
            q = mk_req(REQ_QUERY, 16'($urandom), rnd_pos(k % 4 != 0), rnd_pos(k % 4 != 0),
                       rnd_pos(k % 4 != 0), 23'($urandom_range(0, 60)), $urandom);
            if (k % 5 == 0) q.query_range = 23'($urandom);
         end else if (k < 97) begin
            q = mk_req(REQ_CLEAR, 16'($urandom), 0, 0, 0, 0, 0);
            ids.delete();
         end else begin
            q = mk_req(req_code_type'(3'($urandom_range(5, 7))), 16'($urandom), 0, 0, 0, 0, 0);
         end
         send_req(q);
      end

      wait_drain();
      $display("covered %0d results, %0d query hits, %0d full-pool inserts",
               rsp_count, query_hits, full_count);
      $display("directed extremes, capacity fill, random mix with stalls on both channels");
      if (errors == 0 && pending_rsp.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
